@@ src/coalescing_event_queue_defines.svh @@
// Assertion macros for the coalescing event queue checker
`ifndef COALESCING_EVENT_QUEUE_DEFINES_SVH
`define COALESCING_EVENT_QUEUE_DEFINES_SVH

// Concurrent assertion on the checker clock, muted during reset
`define CEQ_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Implication whose consequent is checked in the next cycle
`define CEQ_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ src/ceq_pkg.sv @@
// Shared types and constants of the coalescing event queue
`timescale 1ns / 1ps

package ceq_pkg;

   // Operation codes of a request transaction
   localparam logic [1:0] MODE_PUSH  = 2'd0;
   localparam logic [1:0] MODE_POP   = 2'd1;
   localparam logic [1:0] MODE_CLEAR = 2'd2;

   // Field widths
   localparam int CARD_W    = 16;
   localparam int ELEMENT_W = 32;
   localparam int MASK_W    = 32;
   localparam int CAP_W     = 5;

   // Register map: one 32-bit register at byte address 0
   localparam int         CSR_ADDR_W    = 3;
   localparam int         CSR_DATA_W    = 32;
   localparam logic       CSR_CAP_INDEX = 1'b0;
   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;
   localparam logic [CAP_W-1:0] CAP_MIN   = 5'd2;

   // One queued event
   typedef struct packed {
      logic [CARD_W-1:0]    card;
      logic [ELEMENT_W-1:0] element;
      logic [MASK_W-1:0]    mask;
   } entry_type;

endpackage

@@ src/ceq_if.sv @@
// Request and response channel interfaces of the coalescing event queue
`timescale 1ns / 1ps

interface ceq_req_if;
   logic                           valid;
   logic                           ready;
   logic [1:0]                     mode;
   logic [ceq_pkg::CARD_W-1:0]     card_in;
   logic [ceq_pkg::ELEMENT_W-1:0]  element_in;
   logic [ceq_pkg::MASK_W-1:0]     mask_in;

   modport source (output valid, mode, card_in, element_in, mask_in, input ready);
   modport sink   (input valid, mode, card_in, element_in, mask_in, output ready);
endinterface

interface ceq_rsp_if #(
   parameter int FILL_W = 5
);
   logic                           valid;
   logic                           ready;
   logic                           ok;
   logic                           merged;
   logic [ceq_pkg::CARD_W-1:0]     card_out;
   logic [ceq_pkg::ELEMENT_W-1:0]  element_out;
   logic [ceq_pkg::MASK_W-1:0]     mask_out;
   logic [FILL_W-1:0]              fill_level;

   modport source (output valid, ok, merged, card_out, element_out, mask_out, fill_level,
                   input ready);
   modport sink   (input valid, ok, merged, card_out, element_out, mask_out, fill_level,
                   output ready);
endinterface

@@ src/coalescing_event_queue.sv @@
// Coalescing event queue: FIFO of change events that merges repeats by card and element
//
// Channel   Dir  Handshake            Carries
// req_bus   in   valid/ready          mode, card_in, element_in, mask_in
// rsp_bus   out  valid/ready          ok, merged, card_out, element_out, mask_out, fill_level
// csr_*     in   APB write/read       capacity_limit at byte address 0
//
// A push walks the queued entries oldest first through the single read port of the
// entry memory, reading then comparing each one; it merges into the first match or,
// after the last, appends or rejects. A pop reads the oldest entry. An empty pop, clear
// and the unused mode go to the response. The next request is taken while a response waits.
// Reset is synchronous and empties the queue; the entry memory itself is not cleared.
// A stalled response holds the sequencer in its last step until the output frees.
`timescale 1ns / 1ps

module coalescing_event_queue #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   ceq_req_if.sink                              req_bus,
   ceq_rsp_if.source                            rsp_bus,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [ceq_pkg::CSR_ADDR_W-1:0]       csr_paddr,
   input  logic [ceq_pkg::CSR_DATA_W-1:0]       csr_pwdata,
   output logic [ceq_pkg::CSR_DATA_W-1:0]       csr_prdata,
   output logic                                 csr_pready
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int LIM_W = (CNT_W > ceq_pkg::CAP_W) ? CNT_W : ceq_pkg::CAP_W;
   localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QUEUE_DEPTH - 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SRCH_RD,
      ST_SRCH_CMP,
      ST_POP_RD,
      ST_POP_DATA,
      ST_RESP
   } state_type;

   // Sequencer and queue control
   state_type                          state_ff, state_in;
   logic [PTR_W-1:0]                   rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0]                   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]                   scan_ptr_ff, scan_ptr_in;
   logic [CNT_W-1:0]                   count_ff, count_in;
   logic [CNT_W-1:0]                   left_ff, left_in;
   logic [ceq_pkg::CAP_W-1:0]          cap_ff, cap_in;

   // Latched request
   ceq_pkg::entry_type                 item_ff, item_in;

   // Pending result
   logic                               res_ok_ff, res_ok_in;
   logic                               res_merged_ff, res_merged_in;
   ceq_pkg::entry_type                 res_entry_ff, res_entry_in;

   // Output register
   logic                               out_valid_ff, out_valid_in;
   logic                               out_ok_ff, out_ok_in;
   logic                               out_merged_ff, out_merged_in;
   ceq_pkg::entry_type                 out_entry_ff, out_entry_in;
   logic [CNT_W-1:0]                   out_fill_ff, out_fill_in;

   // Entry memory
   ceq_pkg::entry_type                 mem [QUEUE_DEPTH];
   ceq_pkg::entry_type                 rd_data_ff;
   logic                               mem_we;
   logic [PTR_W-1:0]                   mem_waddr;
   ceq_pkg::entry_type                 mem_wdata;

   logic                               req_take;
   logic                               out_free;
   logic                               cfg_write;
   logic                               hit;
   logic [LIM_W-1:0]                   limit;
   logic [LIM_W-1:0]                   count_ext;

   function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
      next_slot = (p == LAST_SLOT) ? '0 : p + 1'b1;
   endfunction

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign req_take      = req_bus.valid && req_bus.ready;
   assign out_free      = !out_valid_ff || rsp_bus.ready;

   // Register port: write on the access phase, read back the capacity
   assign csr_pready = 1'b1;
   assign cfg_write  = csr_psel && csr_penable && csr_pwrite &&
                       (csr_paddr[ceq_pkg::CSR_ADDR_W-1] == ceq_pkg::CSR_CAP_INDEX);
   assign csr_prdata = (csr_paddr[ceq_pkg::CSR_ADDR_W-1] == ceq_pkg::CSR_CAP_INDEX) ?
                       ceq_pkg::CSR_DATA_W'(cap_ff) : '0;

   // Saturate the capacity to 2 .. QUEUE_DEPTH
   always_comb begin
      if (cap_ff < ceq_pkg::CAP_MIN) begin
         limit = LIM_W'(ceq_pkg::CAP_MIN);
      end else if (LIM_W'(cap_ff) > LIM_W'(QUEUE_DEPTH)) begin
         limit = LIM_W'(QUEUE_DEPTH);
      end else begin
         limit = LIM_W'(cap_ff);
      end
   end
   assign count_ext = LIM_W'(count_ff);

   // Shared comparator against the entry under the scan pointer
   assign hit = (rd_data_ff.card == item_ff.card) && (rd_data_ff.element == item_ff.element);

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      rd_ptr_in     = rd_ptr_ff;
      wr_ptr_in     = wr_ptr_ff;
      scan_ptr_in   = scan_ptr_ff;
      count_in      = count_ff;
      left_in       = left_ff;
      cap_in        = cfg_write ? csr_pwdata[ceq_pkg::CAP_W-1:0] : cap_ff;
      item_in       = item_ff;
      res_ok_in     = res_ok_ff;
      res_merged_in = res_merged_ff;
      res_entry_in  = res_entry_ff;
      out_valid_in  = out_valid_ff && !rsp_bus.ready;
      out_ok_in     = out_ok_ff;
      out_merged_in = out_merged_ff;
      out_entry_in  = out_entry_ff;
      out_fill_in   = out_fill_ff;
      mem_we        = 1'b0;
      mem_waddr     = wr_ptr_ff;
      mem_wdata     = item_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               item_in.card    = req_bus.card_in;
               item_in.element = req_bus.element_in;
               item_in.mask    = req_bus.mask_in;
               scan_ptr_in   = rd_ptr_ff;
               left_in       = count_ff;
               res_ok_in     = 1'b0;
               res_merged_in = 1'b0;
               res_entry_in  = '0;
               case (req_bus.mode)
                  ceq_pkg::MODE_PUSH: begin
                     state_in = ST_SRCH_RD;
                  end
                  ceq_pkg::MODE_POP: begin
                     state_in = (count_ff == '0) ? ST_RESP : ST_POP_RD;
                  end
                  ceq_pkg::MODE_CLEAR: begin
                     rd_ptr_in = '0;
                     wr_ptr_in = '0;
                     count_in  = '0;
                     res_ok_in = 1'b1;
                     state_in  = ST_RESP;
                  end
                  default: begin
                     state_in = ST_RESP;
                  end
               endcase
            end
         end

         // Wait for the entry read; once every entry is checked, append if below the limit, else reject
         ST_SRCH_RD: begin
            if (left_ff == '0) begin
               if (count_ext < limit) begin
                  mem_we    = 1'b1;
                  mem_waddr = wr_ptr_ff;
                  mem_wdata = item_ff;
                  wr_ptr_in = next_slot(wr_ptr_ff);
                  count_in  = count_ff + 1'b1;
                  res_ok_in = 1'b1;
               end
               state_in = ST_RESP;
            end else begin
               state_in = ST_SRCH_CMP;
            end
         end

         // Merge on a match, else advance to the next entry
         ST_SRCH_CMP: begin
            if (hit) begin
               mem_we         = 1'b1;
               mem_waddr      = scan_ptr_ff;
               mem_wdata      = rd_data_ff;
               mem_wdata.mask = rd_data_ff.mask | item_ff.mask;
               res_ok_in      = 1'b1;
               res_merged_in  = 1'b1;
               state_in       = ST_RESP;
            end else begin
               scan_ptr_in = next_slot(scan_ptr_ff);
               left_in     = left_ff - 1'b1;
               state_in    = ST_SRCH_RD;
            end
         end

         ST_POP_RD: begin
            state_in = ST_POP_DATA;
         end

         ST_POP_DATA: begin
            res_entry_in = rd_data_ff;
            res_ok_in    = 1'b1;
            rd_ptr_in    = next_slot(rd_ptr_ff);
            count_in     = count_ff - 1'b1;
            state_in     = ST_RESP;
         end

         // Hand the result to the output register once it frees
         ST_RESP: begin
            if (out_free) begin
               out_valid_in  = 1'b1;
               out_ok_in     = res_ok_ff;
               out_merged_in = res_merged_ff;
               out_entry_in  = res_entry_ff;
               out_fill_in   = count_ff;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_ptr_ff    <= '0;
         wr_ptr_ff    <= '0;
         scan_ptr_ff  <= '0;
         count_ff     <= '0;
         left_ff      <= '0;
         cap_ff       <= ceq_pkg::CAP_RESET;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_ptr_ff    <= rd_ptr_in;
         wr_ptr_ff    <= wr_ptr_in;
         scan_ptr_ff  <= scan_ptr_in;
         count_ff     <= count_in;
         left_ff      <= left_in;
         cap_ff       <= cap_in;
         out_valid_ff <= out_valid_in;
      end
      item_ff       <= item_in;
      res_ok_ff     <= res_ok_in;
      res_merged_ff <= res_merged_in;
      res_entry_ff  <= res_entry_in;
      out_ok_ff     <= out_ok_in;
      out_merged_ff <= out_merged_in;
      out_entry_ff  <= out_entry_in;
      out_fill_ff   <= out_fill_in;
   end

   // Entry memory: one write port, one registered read at the scan pointer
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[scan_ptr_ff];
   end

   assign rsp_bus.valid       = out_valid_ff;
   assign rsp_bus.ok          = out_ok_ff;
   assign rsp_bus.merged      = out_merged_ff;
   assign rsp_bus.card_out    = out_entry_ff.card;
   assign rsp_bus.element_out = out_entry_ff.element;
   assign rsp_bus.mask_out    = out_entry_ff.mask;
   assign rsp_bus.fill_level  = out_fill_ff;

endmodule

@@ src/ceq_checker.sv @@
// Port-level checks for the coalescing event queue, bound to the top level
`timescale 1ns / 1ps
`include "coalescing_event_queue_defines.svh"

module ceq_checker #(
   parameter int QUEUE_DEPTH = 16
) (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_ready,
   input logic                                 rsp_valid,
   input logic                                 rsp_ready,
   input logic                                 ok,
   input logic                                 merged,
   input logic [ceq_pkg::CARD_W-1:0]           card_out,
   input logic [$clog2(QUEUE_DEPTH + 1)-1:0]   fill_level
);

   localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

   // A pending response stays until taken
   `CEQ_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "response dropped while stalled")

   // The sequencer is busy right after taking a request
   `CEQ_ASSERT_NEXT(a_busy_after_take, req_valid && req_ready, !req_ready, "request taken back to back")

   // A merge is always a successful push and carries no popped event
   `CEQ_ASSERT(a_merge_ok, !(rsp_valid && merged) || (ok && (card_out == '0)), "merge without ok")

   // The fill never exceeds the storage
   `CEQ_ASSERT(a_fill_bound, !rsp_valid || (fill_level <= FILL_W'(QUEUE_DEPTH)), "fill above depth")

endmodule

bind coalescing_event_queue ceq_checker #(
   .QUEUE_DEPTH (QUEUE_DEPTH)
) u_ceq_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_bus.valid),
   .req_ready  (req_bus.ready),
   .rsp_valid  (rsp_bus.valid),
   .rsp_ready  (rsp_bus.ready),
   .ok         (rsp_bus.ok),
   .merged     (rsp_bus.merged),
   .card_out   (rsp_bus.card_out),
   .fill_level (rsp_bus.fill_level)
);
